[hdl/sfsb_pkg.sv]
// Shared types and codes for the sequenced frame stage buffer.
// Request and result structs, request kinds, buffer modes and status codes.
// No dependencies.
package sfsb_pkg;

    typedef enum logic [1:0] {
        REQ_STAGE = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        MODE_EMPTY    = 2'd0,
        MODE_BUFFERED = 2'd1,
        MODE_RUNNING  = 2'd2,
        MODE_STOP     = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_STATE = 3'd2,
        ST_CMD   = 3'd3,
        ST_ORDER = 3'd4,
        ST_FULL  = 3'd5
    } t_status;

    localparam int unsigned CSUM_W = 256;
    localparam int unsigned SEQ_W  = 32;
    localparam int unsigned HELD_W = 5;

    typedef struct packed {
        t_req_kind   req_type;
        logic [63:0] command_tag;
        logic [31:0] sequence_req;
        logic [63:0] checksum_word_0;
        logic [63:0] checksum_word_1;
        logic [63:0] checksum_word_2;
        logic [63:0] checksum_word_3;
    } t_req;

    typedef struct packed {
        t_status     status;
        t_mode       mode_now;
        logic [4:0]  frames_held;
    } t_result;

endpackage

[hdl/sfsb_csum_ram.sv]
// Checksum store: one 256-bit entry per staged frame, registered read.
// A read that hits the entry written at the same edge returns the new data.
// Depends on sfsb_pkg.
module sfsb_csum_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [sfsb_pkg::CSUM_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [sfsb_pkg::CSUM_W-1:0] o_rd_data
);
    import sfsb_pkg::*;

    logic [CSUM_W-1:0] r_mem [0:DEPTH-1];
    logic [CSUM_W-1:0] r_rd_data;
    logic [CSUM_W-1:0] r_byp_data;
    logic              r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_byp_data <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd_data;

endmodule

[hdl/sequenced_frame_stage_buffer.sv]
// An accepted request passes the input register, then the result register, before its result is strobed.
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// The checksum lookup for a duplicate test is read from the store at acceptance.
// Reset (synchronous, active low) clears mode to empty, count and tag to zero.
// Checksum store contents are undefined after reset; no clearing pass is run.
module sequenced_frame_stage_buffer #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  sfsb_pkg::t_req   i_req,
    output logic             busy,
    output logic             o_done,
    output sfsb_pkg::t_result o_result
);
    import sfsb_pkg::*;

    // Address width of the checksum store and width of the frame counter,
    // which must be able to hold CAPACITY itself.
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // Input register: the accepted request waits here while the
    // store read for its sequence number completes.
    t_req             r_req;
    logic             r_req_vld;

    // Architectural state.
    t_mode            r_mode, n_mode;
    logic [CW-1:0]    r_count, n_count;
    logic [63:0]      r_tag, n_tag;

    // Result register.
    t_result          r_res;
    logic             r_done;
    t_status          status;

    logic             accept;
    logic             wr_en;
    logic [CSUM_W-1:0] req_csum;
    logic [CSUM_W-1:0] rd_csum;
    logic [SEQ_W-1:0] count_ext;
    logic [SEQ_W-1:0] n_count_ext;

    // The block never refuses a request.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        r_req <= i_req;
    end

    // The store is read at the incoming sequence number at acceptance. Only
    // sequences below the frame count use the data, and those fit the address.
    sfsb_csum_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_csum_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (req_csum),
        .i_rd_addr (i_req.sequence_req[AW-1:0]),
        .o_rd_data (rd_csum)
    );

    assign req_csum  = {r_req.checksum_word_3, r_req.checksum_word_2,
                        r_req.checksum_word_1, r_req.checksum_word_0};
    assign count_ext = SEQ_W'(r_count);

    // Decision logic for the request held in the input register. State moves
    // only when a request is actually present.
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_tag   = r_tag;
        status  = ST_OK;
        wr_en   = 1'b0;
        if (r_req_vld) begin
            unique case (r_req.req_type)
                REQ_STAGE: begin
                    if (r_mode == MODE_RUNNING || r_mode == MODE_STOP) begin
                        status = ST_STATE;
                    end else begin
                        // The first frame of an empty buffer latches its tag
                        // even when the frame itself is then refused.
                        if (r_count == '0) begin
                            n_tag = r_req.command_tag;
                        end
                        priority if (r_count != '0 && r_tag != r_req.command_tag) begin
                            status = ST_CMD;
                        end else if (r_req.sequence_req < count_ext) begin
                            status = (rd_csum == req_csum) ? ST_DUP : ST_ORDER;
                        end else if (r_req.sequence_req != count_ext) begin
                            status = ST_ORDER;
                        end else if (r_count >= CW'(CAPACITY)) begin
                            status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                            n_mode  = MODE_BUFFERED;
                        end
                    end
                end
                REQ_START: begin
                    priority if (r_mode != MODE_BUFFERED || r_count == '0) begin
                        status = ST_STATE;
                    end else if (r_tag != r_req.command_tag) begin
                        status = ST_CMD;
                    end else begin
                        n_mode = MODE_RUNNING;
                    end
                end
                REQ_STOP: begin
                    n_mode = MODE_STOP;
                end
                REQ_CLEAR: begin
                    n_mode  = MODE_EMPTY;
                    n_count = '0;
                    n_tag   = '0;
                end
                default: begin
                    status = ST_OK;
                end
            endcase
        end
    end

    assign n_count_ext = SEQ_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_done    <= 1'b0;
            r_mode    <= MODE_EMPTY;
            r_count   <= '0;
            r_tag     <= '0;
        end else begin
            r_req_vld <= accept;
            r_done    <= r_req_vld;
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_tag     <= n_tag;
        end
    end

    // The reported frame count is the counter's new value masked to the result width.
    always_ff @(posedge i_clk) begin
        r_res.status      <= status;
        r_res.mode_now    <= n_mode;
        r_res.frames_held <= n_count_ext[HELD_W-1:0];
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    // Every accepted request produces exactly one strobed result, through the input and result registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_done)
        else $error("accepted request produced no result");

    // The frame counter never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("frame count above capacity");

    // A store write only lands in a free slot.
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_count < CW'(CAPACITY)))
        else $error("checksum written into a full buffer");

    // Running is only reachable with frames held.
    a_run_has_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_RUNNING) |-> (r_count != '0))
        else $error("running with no frames");

    // An empty buffer holds no frames.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_EMPTY) |-> (r_count == '0))
        else $error("empty mode with frames held");

endmodule
